>>> rtl/odtt_pkg.sv
// Shared types and constants of the on/off delayed transition timer.
package odtt_pkg;

    // Channel and timing geometry.
    localparam int NUM_LEDS = 4;
    localparam int MAX_RES  = 4;
    localparam int CH_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int CNT_W    = $clog2(MAX_RES + 1);
    localparam int IDX_W    = 2;
    localparam int TIME_W   = 26;
    localparam int DLY_W    = 11;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // Input command codes.
    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_GET  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // Result kind codes.
    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_PUBLISH = 2'd1;
    localparam logic [1:0] KIND_DRIVE   = 2'd2;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_SET,
        OP_GET,
        OP_TICK
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [IDX_W-1:0]    ch;
        logic                tgt;
        logic [TIME_W-1:0]   trans;
        logic [DLY_W-1:0]    dly;
    } op_t;

    // One result item as the back end produces it.
    typedef struct packed {
        logic [1:0]          kind;
        logic [IDX_W-1:0]    channel;
        logic                led_on;
        logic [TIME_W-1:0]   remaining;
        logic                target;
        logic                present;
        logic                last;
    } result_t;

endpackage

>>> rtl/odtt_front.sv
// Front end: decodes incoming items and drops those that cause nothing.
module odtt_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              q_full,
    output logic              q_push,
    output odtt_pkg::op_t     q_op
);
    import odtt_pkg::*;

    logic in_range;
    logic useful;

    // Field extraction and classification.
    always_comb begin
        q_op.ch    = s_tdata[1:0];
        q_op.tgt   = s_tdata[2];
        q_op.trans = s_tdata[28:3];
        q_op.dly   = s_tdata[39:29];
        in_range   = (32'(s_tdata[1:0]) < NUM_LEDS);
        case (s_tuser)
            CMD_SET: begin
                q_op.kind = OP_SET;
                useful    = in_range;
            end
            CMD_GET: begin
                q_op.kind = OP_GET;
                useful    = in_range;
            end
            CMD_TICK: begin
                q_op.kind = OP_TICK;
                useful    = 1'b1;
            end
            default: begin
                q_op.kind = OP_TICK;
                useful    = 1'b0;
            end
        endcase
    end

    // Items that cause nothing are taken and discarded.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && useful;

endmodule

>>> rtl/odtt_queue.sv
// Short operation queue between the front end and the back end.
module odtt_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  odtt_pkg::op_t     push_op,
    input  logic              pop,
    output odtt_pkg::op_t     head_op,
    output logic              empty,
    output logic              full
);
    import odtt_pkg::*;

    op_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign head_op = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> rtl/odtt_back.sv
// Back end: per-channel state, set/get handling and the tick channel scan.
module odtt_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  odtt_pkg::op_t     head_op,
    output logic              pop,
    input  logic              m_tready,
    output logic              res_valid,
    output odtt_pkg::result_t res
);
    import odtt_pkg::*;

    // Per-channel state.
    logic              target_reg  [NUM_LEDS];
    logic [TIME_W-1:0] pending_reg [NUM_LEDS];
    logic [TIME_W-1:0] count_reg   [NUM_LEDS];
    logic              armed_reg   [NUM_LEDS];
    logic              drive_reg   [NUM_LEDS];

    logic [CH_W-1:0]   scan_reg;
    logic [CH_W-1:0]   scan_next;
    logic [CNT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic              valid_reg, valid_next;
    result_t           res_reg, res_next;

    logic              is_tick;
    logic [CH_W-1:0]   sel;
    logic              cur_target, cur_armed, cur_drive;
    logic [TIME_W-1:0] cur_pending, cur_count;
    logic              target_next, armed_next, drive_next;
    logic [TIME_W-1:0] pending_next, count_next;
    logic              emit, last, more;
    logic [1:0]        kind;
    logic [TIME_W-1:0] rem;
    logic              out_free, step;

    assign is_tick  = (head_op.kind == OP_TICK);
    assign sel      = is_tick ? scan_reg : CH_W'(head_op.ch);
    assign out_free = !valid_reg || m_tready;

    // Read the addressed channel.
    always_comb begin
        cur_target  = target_reg[sel];
        cur_pending = pending_reg[sel];
        cur_count   = count_reg[sel];
        cur_armed   = armed_reg[sel];
        cur_drive   = drive_reg[sel];
    end

    // A later channel that expires on this tick keeps the burst open.
    always_comb begin
        more = 1'b0;
        for (int j = 0; j < NUM_LEDS; j++) begin
            if (j > int'(scan_reg) && armed_reg[j] && count_reg[j] <= TIME_W'(1)) begin
                more = 1'b1;
            end
        end
    end

    // Channel update and result selection.
    always_comb begin
        target_next  = cur_target;
        pending_next = cur_pending;
        count_next   = cur_count;
        armed_next   = cur_armed;
        drive_next   = cur_drive;
        emit         = 1'b0;
        last         = 1'b1;
        kind         = KIND_REPLY;
        case (head_op.kind)
            OP_SET: begin
                emit = 1'b1;
                if (head_op.tgt != cur_target) begin
                    target_next = head_op.tgt;
                    if (head_op.trans == '0 && head_op.dly == '0) begin
                        pending_next = '0;
                        drive_next   = head_op.tgt;
                    end else if (head_op.dly != '0) begin
                        pending_next = head_op.trans;
                        count_next   = TIME_W'(head_op.dly);
                        armed_next   = 1'b1;
                    end else begin
                        drive_next   = 1'b1;
                        count_next   = head_op.trans;
                        armed_next   = 1'b1;
                        pending_next = '0;
                    end
                end
            end
            OP_GET: begin
                emit = 1'b1;
            end
            OP_TICK: begin
                if (cur_armed) begin
                    if (cur_count > TIME_W'(1)) begin
                        count_next = cur_count - 1'b1;
                    end else begin
                        emit = (emit_cnt_reg < CNT_W'(MAX_RES));
                        last = !more || (emit_cnt_reg == CNT_W'(MAX_RES - 1));
                        if (cur_pending != '0) begin
                            drive_next   = 1'b1;
                            count_next   = cur_pending;
                            armed_next   = 1'b1;
                            pending_next = '0;
                            kind         = KIND_DRIVE;
                        end else begin
                            count_next = '0;
                            armed_next = 1'b0;
                            drive_next = cur_target;
                            kind       = KIND_PUBLISH;
                        end
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Status of the channel after the update.
    assign rem = (pending_next != '0) ? pending_next : (armed_next ? count_next : '0);

    // Advance unless a result must wait for the output register.
    assign step = head_valid && (!emit || out_free);
    assign pop  = step && (!is_tick || scan_reg == CH_W'(NUM_LEDS - 1));

    // Scan position, burst count and output register.
    always_comb begin
        scan_next     = scan_reg;
        emit_cnt_next = emit_cnt_reg;
        valid_next    = m_tready ? 1'b0 : valid_reg;
        res_next      = res_reg;
        if (step && is_tick) begin
            if (pop) begin
                scan_next     = '0;
                emit_cnt_next = '0;
            end else begin
                scan_next = scan_reg + 1'b1;
                if (emit) begin
                    emit_cnt_next = emit_cnt_reg + 1'b1;
                end
            end
        end
        if (step && emit) begin
            valid_next       = 1'b1;
            res_next.kind    = kind;
            res_next.channel = IDX_W'(sel);
            res_next.led_on  = drive_next;
            res_next.remaining = rem;
            res_next.target  = target_next;
            res_next.present = target_next || (rem != '0);
            res_next.last    = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg     <= '0;
            emit_cnt_reg <= '0;
            valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                target_reg[i]  <= 1'b0;
                pending_reg[i] <= '0;
                count_reg[i]   <= '0;
                armed_reg[i]   <= 1'b0;
                drive_reg[i]   <= 1'b0;
            end
        end else begin
            scan_reg     <= scan_next;
            emit_cnt_reg <= emit_cnt_next;
            valid_reg    <= valid_next;
            if (step) begin
                target_reg[sel]  <= target_next;
                pending_reg[sel] <= pending_next;
                count_reg[sel]   <= count_next;
                armed_reg[sel]   <= armed_next;
                drive_reg[sel]   <= drive_next;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

>>> rtl/onoff_delayed_transition_timer.sv
// Top level of the on/off delayed transition timer.
//
// Input items arrive on the s_ stream: tuser carries the command (set target,
// get status or a one millisecond tick) and tdata the channel, target,
// transition time and delay. Results leave on the m_ stream: tuser carries
// the result kind, tdata the channel status and tlast marks the last result
// that an input item causes.
// A set or get gives one status result, which passes through the queue and
// then the output register. A tick walks all NUM_LEDS channels through one
// shared update unit, one channel a cycle unless a result waits for the output
// register, and gives one result per expiring channel, at most MAX_RES of them.
// Sets and gets are taken one per cycle while the queue is not full. A two-entry
// queue separates the decoder from the channel unit. The single output register
// holds one result, so the channel unit moves on to a step that gives a result
// only in a cycle where the held result is taken or none is held. Commands that
// mean nothing and out-of-range channels are taken and dropped.
// Reset clears all channel state, the queue pointers and the output valid flag.
// When the receiver stalls, the result is held, the channel unit waits and
// the queue fills before s_tready drops.
module onoff_delayed_transition_timer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // led_index[1:0], target_on[2], transition_ms[28:3],
                                   // delay_ms[39:29]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // led_channel[1:0], led_on[2], remaining_ms[28:3],
                                   // target_state[29], present_state[30], zero[31]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import odtt_pkg::*;

    logic    q_full, q_empty, q_push, q_pop;
    op_t     push_op, head_op;
    result_t res;

    odtt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    odtt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .empty   (q_empty),
        .full    (q_full)
    );

    odtt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!q_empty),
        .head_op    (head_op),
        .pop        (q_pop),
        .m_tready   (m_tready),
        .res_valid  (m_tvalid),
        .res        (res)
    );

    // Pack the result item onto the output stream.
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {1'b0, res.present, res.target, res.remaining, res.led_on, res.channel};

    // A status reply always closes its burst.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_REPLY) |-> m_tlast)
        else $error("status reply without last marker");

    // A drive change result always reports the drive on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_DRIVE) |-> m_tdata[2])
        else $error("drive change result with drive off");

    // Present state follows target and remaining time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30] == (m_tdata[29] || (m_tdata[28:3] != '0))))
        else $error("present state inconsistent with status");

    // No result is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the on/off delayed transition timer.
`timescale 1ns / 100ps

module tb;
    import odtt_pkg::*;

    // Command code that the block takes and drops.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Largest legal transition time and delay.
    localparam logic [TIME_W-1:0] TRANS_MAX = TIME_W'(37200000);
    localparam logic [DLY_W-1:0]  DLY_MAX   = DLY_W'(1275);

    localparam int ITEMS_PER_PHASE = 120;
    localparam int DRAIN_CYCLES    = 4 * NUM_LEDS + 16;
    localparam int CYCLE_LIMIT     = 400000;

    // Tracks the channel state and holds the results that are still due.
    class led_status_scoreboard;
        logic              target_v  [NUM_LEDS];
        logic [TIME_W-1:0] pending_t [NUM_LEDS];
        logic [TIME_W-1:0] timer_cnt [NUM_LEDS];
        logic              timer_on  [NUM_LEDS];
        logic              drive_on  [NUM_LEDS];
        result_t           due_q[$];

        function new();
            for (int i = 0; i < NUM_LEDS; i++) begin
                target_v[i]  = 1'b0;
                pending_t[i] = '0;
                timer_cnt[i] = '0;
                timer_on[i]  = 1'b0;
                drive_on[i]  = 1'b0;
            end
        endfunction

        function int waiting();
            return due_q.size();
        endfunction

        function string describe(result_t r);
            return $sformatf("kind=%0d ch=%0d on=%0b rem=%0d tgt=%0b pres=%0b last=%0b",
                             r.kind, r.channel, r.led_on, r.remaining, r.target,
                             r.present, r.last);
        endfunction

        // Status of one channel as it stands now.
        function result_t status_of(logic [1:0] kind, int ch);
            result_t           r;
            logic [TIME_W-1:0] rem;
            rem = (pending_t[ch] != '0) ? pending_t[ch]
                : (timer_on[ch] ? timer_cnt[ch] : '0);
            r.kind      = kind;
            r.channel   = IDX_W'(ch);
            r.led_on    = drive_on[ch];
            r.remaining = rem;
            r.target    = target_v[ch];
            r.present   = target_v[ch] | (rem != '0);
            r.last      = 1'b0;
            return r;
        endfunction

        // The drive goes on and the timer runs for the pending time.
        function void start_fade(int ch);
            drive_on[ch]  = 1'b1;
            timer_cnt[ch] = pending_t[ch];
            timer_on[ch]  = 1'b1;
            pending_t[ch] = '0;
        endfunction

        // Updates the channel state for an accepted item and queues its results.
        function void note_item(logic [1:0] cmd, logic [IDX_W-1:0] idx, logic tgt,
                                logic [TIME_W-1:0] trans, logic [DLY_W-1:0] dly);
            result_t    r;
            result_t    held;
            logic       have_held;
            logic [1:0] kind;
            int         ch;
            int         n;
            ch        = int'(idx);
            n         = 0;
            have_held = 1'b0;
            if (cmd == CMD_SET || cmd == CMD_GET) begin
                if (ch >= NUM_LEDS) return;
                if (cmd == CMD_SET && tgt != target_v[ch]) begin
                    target_v[ch] = tgt;
                    if (trans == '0 && dly == '0) begin
                        pending_t[ch] = '0;
                        drive_on[ch]  = tgt;
                    end else begin
                        pending_t[ch] = trans;
                        if (dly != '0) begin
                            timer_cnt[ch] = TIME_W'(dly);
                            timer_on[ch]  = 1'b1;
                        end else begin
                            start_fade(ch);
                        end
                    end
                end
                r      = status_of(KIND_REPLY, ch);
                r.last = 1'b1;
                due_q.push_back(r);
            end else if (cmd == CMD_TICK) begin
                for (int i = 0; i < NUM_LEDS; i++) begin
                    if (timer_on[i]) begin
                        if (timer_cnt[i] > 1) begin
                            timer_cnt[i] = timer_cnt[i] - 1'b1;
                        end else begin
                            timer_cnt[i] = '0;
                            timer_on[i]  = 1'b0;
                            if (pending_t[i] != '0) begin
                                start_fade(i);
                                kind = KIND_DRIVE;
                            end else begin
                                drive_on[i] = target_v[i];
                                kind = KIND_PUBLISH;
                            end
                            if (n < MAX_RES) begin
                                // Hold each result back until we know whether it is the last.
                                if (have_held) due_q.push_back(held);
                                held      = status_of(kind, i);
                                have_held = 1'b1;
                                n++;
                            end
                        end
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    due_q.push_back(held);
                end
            end
        endfunction

        // Compares a result with the oldest one due; returns a description on mismatch.
        function string check_result(result_t got);
            result_t want;
            string   diffs;
            if (due_q.size() == 0) return {"unexpected result: ", describe(got)};
            want  = due_q.pop_front();
            diffs = "";
            if (got.kind != want.kind)           diffs = {diffs, " kind"};
            if (got.channel != want.channel)     diffs = {diffs, " channel"};
            if (got.led_on != want.led_on)       diffs = {diffs, " led_on"};
            if (got.remaining != want.remaining) diffs = {diffs, " remaining"};
            if (got.target != want.target)       diffs = {diffs, " target"};
            if (got.present != want.present)     diffs = {diffs, " present"};
            if (got.last != want.last)           diffs = {diffs, " last"};
            if (diffs == "") return "";
            return {"wrong", diffs, ": got ", describe(got), " want ", describe(want)};
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    led_status_scoreboard board;
    int mismatches     = 0;
    int cycles         = 0;
    int send_idle_pct  = 10;
    int recv_stall_pct = 50;

    onoff_delayed_transition_timer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report(string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // Offers one item, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_item(logic [1:0] cmd, logic [IDX_W-1:0] idx, logic tgt,
                             logic [TIME_W-1:0] trans, logic [DLY_W-1:0] dly);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {dly, trans, tgt, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_item(cmd, idx, tgt, trans, dly);
    endtask

    // Time values are mostly short so that timers run out, now and then anywhere in range.
    function automatic logic [TIME_W-1:0] pick_trans();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return '0;
        if (sel < 95) return TIME_W'($urandom_range(1, 5));
        return TIME_W'($urandom_range(0, int'(TRANS_MAX)));
    endfunction

    function automatic logic [DLY_W-1:0] pick_delay();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) return '0;
        if (sel < 95) return DLY_W'($urandom_range(1, 5));
        return DLY_W'($urandom_range(0, int'(DLY_MAX)));
    endfunction

    // One random item; counted is cleared for items that the block drops.
    task automatic send_random(output bit counted);
        int         sel;
        logic [1:0] cmd;
        sel = $urandom_range(99);
        cmd = (sel < 30) ? CMD_SET : (sel < 42) ? CMD_GET : (sel < 94) ? CMD_TICK : CMD_UNUSED;
        counted = (cmd != CMD_UNUSED);
        if (cmd == CMD_UNUSED) begin
            send_item(cmd, IDX_W'($urandom()), 1'($urandom()),
                      TIME_W'($urandom()), DLY_W'($urandom()));
        end else begin
            send_item(cmd, IDX_W'($urandom_range(0, NUM_LEDS - 1)), 1'($urandom()),
                      pick_trans(), pick_delay());
        end
    endtask

    // Result side: random stalls, checking and the cycle limit.
    always @(posedge aclk) begin
        result_t got;
        string   msg;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            if (aresetn && m_tvalid && m_tready) begin
                got.kind      = m_tuser;
                got.channel   = m_tdata[1:0];
                got.led_on    = m_tdata[2];
                got.remaining = m_tdata[28:3];
                got.target    = m_tdata[29];
                got.present   = m_tdata[30];
                got.last      = m_tlast;
                msg = board.check_result(got);
                if (msg != "") report(msg);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        bit counted;
        int done;
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: immediate, delayed and faded changes, repeats and a full tick.
        send_item(CMD_GET,  2'd0, 1'b0, '0, '0);
        send_item(CMD_SET,  2'd0, 1'b1, '0, '0);
        send_item(CMD_SET,  2'd0, 1'b1, '0, '0);
        send_item(CMD_SET,  2'd1, 1'b1, TIME_W'(2), '0);
        send_item(CMD_SET,  2'd2, 1'b1, TIME_W'(1), DLY_W'(2));
        send_item(CMD_TICK, 2'd0, 1'b0, '0, '0);
        send_item(CMD_TICK, 2'd0, 1'b0, '0, '0);
        send_item(CMD_TICK, 2'd0, 1'b0, '0, '0);
        send_item(CMD_UNUSED, '1, 1'b1, '1, '1);
        send_item(CMD_SET,  2'd3, 1'b1, TRANS_MAX, DLY_MAX);
        send_item(CMD_GET,  2'd3, 1'b0, '0, '0);
        // An immediate change leaves the running timer alone.
        send_item(CMD_SET,  2'd3, 1'b0, '0, '0);
        send_item(CMD_GET,  2'd3, 1'b1, TRANS_MAX, DLY_MAX);
        send_item(CMD_SET,  2'd3, 1'b1, '0, DLY_W'(1));
        send_item(CMD_SET,  2'd0, 1'b0, '0, DLY_W'(1));
        send_item(CMD_SET,  2'd1, 1'b0, TIME_W'(1), '0);
        send_item(CMD_SET,  2'd2, 1'b0, '0, DLY_W'(1));
        // All four channels run out on the same tick.
        send_item(CMD_TICK, 2'd0, 1'b0, '0, '0);
        send_item(CMD_TICK, 2'd0, 1'b0, '0, '0);
        send_item(CMD_GET,  2'd1, 1'b0, '0, '0);
        send_item(CMD_GET,  2'd2, 1'b0, '0, '0);

        // Random part in three pacing phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 10 : (phase == 1) ? 50 : 0;
            recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 10 : 0;
            done = 0;
            while (done < ITEMS_PER_PHASE) begin
                send_random(counted);
                if (counted) done++;
            end
        end
        s_tvalid <= 1'b0;

        while (board.waiting() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
